// ===== rtl/fermion_correlation_matrix_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fermion correlation matrix block
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FERMION_CORRELATION_MATRIX_DEFINES_SVH
`define FERMION_CORRELATION_MATRIX_DEFINES_SVH

`ifndef SYNTH
// check on an explicit clock and reset
`define FCM_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on the block clock and reset
`define FCM_ASSERT(lbl, prop, msg) `FCM_ASSERT_CLK(lbl, clock, reset, prop, msg)
`else
`define FCM_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define FCM_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/fcm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared widths, codes and the command item passed from front to back.
// ----------------------------------------------------------------------------
package fcm_pkg;

   // field widths
   localparam int IDX_W    = 4;
   localparam int ELEM_W   = 16;
   localparam int CORR_W   = 32;
   localparam int CFG_W    = 5;
   localparam int FILL_W   = 5;
   localparam int STORE_W  = 2 * ELEM_W;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_IN_USE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILLED_COUNT = 1'b1;

   // item modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classified item
   typedef struct packed {
      logic                     is_read;
      logic                     skip;     // write: dropped; read: zero result
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [ELEM_W-1:0] elem_re;
      logic signed [ELEM_W-1:0] elem_im;
      logic [FILL_W-1:0]        ne;       // columns to sum
   } fcm_cmd_type;

endpackage

// ===== rtl/fcm_if.sv =====
// ----------------------------------------------------------------------------
// fcm channel interfaces
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
interface fcm_req_if;
   logic                             valid;
   logic                             ready;
   logic                             mode;
   logic [fcm_pkg::IDX_W-1:0]        row_index;
   logic [fcm_pkg::IDX_W-1:0]        col_index;
   logic signed [fcm_pkg::ELEM_W-1:0] elem_re;
   logic signed [fcm_pkg::ELEM_W-1:0] elem_im;

   modport source (output valid, mode, row_index, col_index, elem_re, elem_im,
                   input ready);
   modport sink   (input valid, mode, row_index, col_index, elem_re, elem_im,
                   output ready);
endinterface

interface fcm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [fcm_pkg::CORR_W-1:0] corr_re;
   logic signed [fcm_pkg::CORR_W-1:0] corr_im;

   modport source (output valid, corr_re, corr_im, input ready);
   modport sink   (input valid, corr_re, corr_im, output ready);
endinterface

interface fcm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fcm_pkg::CSR_IDX_W-1:0]   index;
   logic [fcm_pkg::CFG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fcm_front.sv =====
// ----------------------------------------------------------------------------
// fcm_front
// Holds the configuration registers and classifies each request item.
// ----------------------------------------------------------------------------
module fcm_front #(
   parameter int MAX_SITES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   fcm_req_if.sink              req_chan,
   fcm_csr_if.sink              csr_chan,
   output fcm_pkg::fcm_cmd_type cmd,
   output logic                 cmd_valid,
   input  logic                 cmd_ready
);

   localparam int CNT_W = $clog2(MAX_SITES + 1);
   localparam int CMP_W = (CNT_W > fcm_pkg::CFG_W) ? CNT_W : fcm_pkg::CFG_W;

   logic [fcm_pkg::CFG_W-1:0] size_ff, size_in;
   logic [fcm_pkg::CFG_W-1:0] fill_ff, fill_in;
   logic [CMP_W-1:0]          size_ext, fill_ext, eff_n, ne_full;
   logic [CMP_W-1:0]          row_ext, col_ext;

   // register writes, always taken
   assign csr_chan.ready = 1'b1;

   always_comb begin
      size_in = size_ff;
      fill_in = fill_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            fcm_pkg::CSR_SIZE_IN_USE:  size_in = csr_chan.data;
            fcm_pkg::CSR_FILLED_COUNT: fill_in = csr_chan.data;
            default:                   size_in = size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= fcm_pkg::CFG_W'(16);
         fill_ff <= '0;
      end else begin
         size_ff <= size_in;
         fill_ff <= fill_in;
      end
   end

   // effective size and occupied count
   assign size_ext = CMP_W'(size_ff);
   assign fill_ext = CMP_W'(fill_ff);
   assign row_ext  = CMP_W'(req_chan.row_index);
   assign col_ext  = CMP_W'(req_chan.col_index);

   always_comb begin
      priority if (size_ff == '0) begin
         eff_n = CMP_W'(1);
      end else if (size_ext > CMP_W'(MAX_SITES)) begin
         eff_n = CMP_W'(MAX_SITES);
      end else begin
         eff_n = size_ext;
      end
   end

   assign ne_full = (fill_ext < eff_n) ? fill_ext : eff_n;

   // classify the item
   always_comb begin
      cmd.is_read = (req_chan.mode == fcm_pkg::MODE_READ);
      cmd.row     = req_chan.row_index;
      cmd.col     = req_chan.col_index;
      cmd.elem_re = req_chan.elem_re;
      cmd.elem_im = req_chan.elem_im;
      cmd.ne      = fcm_pkg::FILL_W'(ne_full);
      if (req_chan.mode == fcm_pkg::MODE_READ) begin
         cmd.skip = (row_ext >= eff_n) || (col_ext >= eff_n);
      end else begin
         cmd.skip = (row_ext >= CMP_W'(MAX_SITES)) || (col_ext >= CMP_W'(MAX_SITES));
      end
   end

   assign cmd_valid      = req_chan.valid;
   assign req_chan.ready = cmd_ready;

endmodule

// ===== rtl/fcm_queue.sv =====
// ----------------------------------------------------------------------------
// fcm_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`include "fermion_correlation_matrix_defines.svh"

module fcm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  fcm_pkg::fcm_cmd_type in_cmd,
   input  logic                 in_valid,
   output logic                 in_ready,
   output fcm_pkg::fcm_cmd_type out_cmd,
   output logic                 out_valid,
   input  logic                 out_ready
);

   fcm_pkg::fcm_cmd_type               entry_ff [fcm_pkg::QUEUE_DEPTH];
   logic [fcm_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [fcm_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [fcm_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                               push, pop;

   assign in_ready  = (count_ff != fcm_pkg::QCNT_W'(fcm_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_cmd   = entry_ff[rd_ptr_ff];

   // pointers wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fcm_pkg::QPTR_W'(fcm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + fcm_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fcm_pkg::QPTR_W'(fcm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + fcm_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + fcm_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - fcm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   `FCM_ASSERT(a_q_count_bound, count_ff <= fcm_pkg::QCNT_W'(fcm_pkg::QUEUE_DEPTH), "queue count above depth")

endmodule

// ===== rtl/fcm_back.sv =====
// ----------------------------------------------------------------------------
// fcm_back
// Orbital store, column-serial complex multiply-accumulate and result register.
// ----------------------------------------------------------------------------
`include "fermion_correlation_matrix_defines.svh"

module fcm_back #(
   parameter int MAX_SITES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fcm_pkg::fcm_cmd_type cmd,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   fcm_rsp_if.source            rsp_chan
);

   localparam int STORE_DEPTH = MAX_SITES * MAX_SITES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ACC_W       = 38;    // up to MAX_SITES (16) terms of up to 2^31 each, signed
   localparam int RND_DROP    = 4;     // 30 fraction bits down to 26
   localparam int Q_W         = ACC_W + 1 - RND_DROP;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [fcm_pkg::FILL_W-1:0]         k_ff, k_in;
   logic [fcm_pkg::FILL_W-1:0]         ne_ff, ne_in;
   logic [fcm_pkg::IDX_W-1:0]          row_ff, row_in;
   logic [fcm_pkg::IDX_W-1:0]          col_ff, col_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [fcm_pkg::CORR_W-1:0]  corr_re_ff, corr_re_in;
   logic signed [fcm_pkg::CORR_W-1:0]  corr_im_ff, corr_im_in;

   logic                               pop, mem_we, rd_en, acc_clr;
   logic [ADDR_W-1:0]                  wr_addr, addr_a, addr_b;
   logic [fcm_pkg::STORE_W-1:0]        mem [STORE_DEPTH];
   logic [fcm_pkg::STORE_W-1:0]        rd_a_ff, rd_b_ff;

   logic                               s1_valid_ff, s2_valid_ff;
   logic signed [fcm_pkg::ELEM_W-1:0]  a_re, a_im, b_re, b_im;
   logic signed [2*fcm_pkg::ELEM_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [ACC_W-1:0]            acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;

   // floor((v + 8) / 16), saturated to 32 bits
   function automatic logic signed [fcm_pkg::CORR_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] v
   );
      logic [ACC_W:0]   sum;
      logic [Q_W-1:0]   q;
      logic [Q_W-fcm_pkg::CORR_W:0] top;
      sum = {v[ACC_W-1], v} + (ACC_W + 1)'(1 << (RND_DROP - 1));
      q   = sum[ACC_W:RND_DROP];
      top = q[Q_W-1:fcm_pkg::CORR_W-1];
      if ((&top) || !(|top)) begin
         round_sat = q[fcm_pkg::CORR_W-1:0];
      end else if (q[Q_W-1]) begin
         round_sat = {1'b1, {(fcm_pkg::CORR_W-1){1'b0}}};
      end else begin
         round_sat = {1'b0, {(fcm_pkg::CORR_W-1){1'b1}}};
      end
   endfunction

   // store addressing: element (r,k) at r*MAX_SITES+k
   assign wr_addr = ADDR_W'(cmd.row) * ADDR_W'(MAX_SITES) + ADDR_W'(cmd.col);
   assign addr_a  = ADDR_W'(row_ff) * ADDR_W'(MAX_SITES) + ADDR_W'(k_ff);
   assign addr_b  = ADDR_W'(col_ff) * ADDR_W'(MAX_SITES) + ADDR_W'(k_ff);

   assign cmd_ready = (state_ff == ST_IDLE);
   assign pop       = cmd_valid && cmd_ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      ne_in        = ne_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      corr_re_in   = corr_re_ff;
      corr_im_in   = corr_im_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      acc_clr      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (!cmd.is_read) begin
                  mem_we = !cmd.skip;
               end else begin
                  row_in  = cmd.row;
                  col_in  = cmd.col;
                  ne_in   = cmd.ne;
                  k_in    = '0;
                  acc_clr = 1'b1;
                  state_in = (cmd.skip || (cmd.ne == '0)) ? ST_DONE : ST_RUN;
               end
            end
         end
         ST_RUN: begin
            rd_en = 1'b1;
            k_in  = k_ff + fcm_pkg::FILL_W'(1);
            if (k_ff == ne_ff - fcm_pkg::FILL_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               corr_re_in   = round_sat(acc_re_ff);
               corr_im_in   = round_sat(acc_im_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         ne_ff        <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         ne_ff        <= ne_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      corr_re_ff <= corr_re_in;
      corr_im_ff <= corr_im_in;
   end

   // orbital store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= {cmd.elem_im, cmd.elem_re};
      end
      if (rd_en) begin
         rd_a_ff <= mem[addr_a];
         rd_b_ff <= mem[addr_b];
      end
   end

   // products of conj(a) and b
   assign a_re = $signed(rd_a_ff[fcm_pkg::ELEM_W-1:0]);
   assign a_im = $signed(rd_a_ff[fcm_pkg::STORE_W-1:fcm_pkg::ELEM_W]);
   assign b_re = $signed(rd_b_ff[fcm_pkg::ELEM_W-1:0]);
   assign b_im = $signed(rd_b_ff[fcm_pkg::STORE_W-1:fcm_pkg::ELEM_W]);

   always_ff @(posedge clock) begin
      p_rr_ff <= a_re * b_re;
      p_ii_ff <= a_im * b_im;
      p_ri_ff <= a_re * b_im;
      p_ir_ff <= a_im * b_re;
   end

   // accumulate one column per cycle
   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (acc_clr) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (s2_valid_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(p_rr_ff) + ACC_W'(p_ii_ff);
         acc_im_in = acc_im_ff + ACC_W'(p_ri_ff) - ACC_W'(p_ir_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff;
      end
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.corr_re = corr_re_ff;
   assign rsp_chan.corr_im = corr_im_ff;

   `FCM_ASSERT(a_b_prod_follows_read, s2_valid_ff |-> $past(s1_valid_ff), "product without read data")
   `FCM_ASSERT(a_b_read_in_run, s1_valid_ff |-> $past(state_ff == ST_RUN), "store read outside run")
   `FCM_ASSERT(a_b_done_drained, (state_ff == ST_DONE) |-> (!s1_valid_ff && !s2_valid_ff), "result before drain")

endmodule

// ===== rtl/fermion_correlation_matrix.sv =====
// ----------------------------------------------------------------------------
// fermion_correlation_matrix
// Orbital matrix store with correlation entry readout C(i,j).
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  req_chan  in   valid/ready   mode, row_index, col_index, elem_re, elem_im
//  rsp_chan  out  valid/ready   corr_re, corr_im (one per read item)
//  csr_chan  in   valid/ready   index, data (always ready)
//
//  A write item is stored by the back end directly; a read item walks Ne
//  columns (none when Ne is 0 or the pair is outside the size) through the shared
//  complex multiply-accumulate, one column per cycle, before the next item is taken.
//  Reset sets size_in_use to 16 and filled_count to 0; the store is not cleared.
//  A two-item queue lets the front accept while the back works, and the result
//  register holds a result while the next item proceeds.
// ----------------------------------------------------------------------------
module fermion_correlation_matrix #(
   parameter int MAX_SITES = 16
) (
   input  logic       clock,
   input  logic       reset,
   fcm_req_if.sink    req_chan,
   fcm_rsp_if.source  rsp_chan,
   fcm_csr_if.sink    csr_chan
);

   fcm_pkg::fcm_cmd_type front_cmd, back_cmd;
   logic                 front_valid, front_ready;
   logic                 back_valid, back_ready;

   fcm_front #(
      .MAX_SITES (MAX_SITES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .cmd       (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   fcm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_cmd    (front_cmd),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_cmd   (back_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   fcm_back #(
      .MAX_SITES (MAX_SITES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== sim/fcm_corr_check.sv =====
// ----------------------------------------------------------------------------
// fcm_corr_check
// Passive monitor for the correlation matrix block. It tracks register
// writes and orbital element writes, predicts C(i,j) for every accepted
// read item and compares each result item field by field, in order.
// ----------------------------------------------------------------------------
module fcm_corr_check #(
   parameter int SITES = 16
) (
   input  logic clock,
   input  logic reset,
   fcm_req_if   req_chan,
   fcm_rsp_if   rsp_chan,
   fcm_csr_if   csr_chan,
   output int   errors,
   output int   results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [fcm_pkg::CORR_W-1:0] re;
      logic signed [fcm_pkg::CORR_W-1:0] im;
   } corr_pair_type;

   // shadow copy of the orbital matrix and the two registers
   logic signed [fcm_pkg::ELEM_W-1:0] orb_re [SITES][SITES];
   logic signed [fcm_pkg::ELEM_W-1:0] orb_im [SITES][SITES];
   logic [fcm_pkg::CFG_W-1:0]         size_reg;
   logic [fcm_pkg::FILL_W-1:0]        fill_reg;

   corr_pair_type corr_expected_q[$];

   // 30 fraction bits down to 26, half up, then clamp to 32 bits
   function automatic logic signed [fcm_pkg::CORR_W-1:0] to_q5_26(input longint sum30);
      longint r;
      r = (sum30 + 8) >>> 4;
      if (r > 64'sd2147483647)
         r = 64'sd2147483647;
      if (r < -64'sd2147483648)
         r = -64'sd2147483648;
      return r[fcm_pkg::CORR_W-1:0];
   endfunction

   // C(i,j) = sum over k < Ne of conj(U(i,k)) * U(j,k)
   function automatic corr_pair_type correlate(input logic [fcm_pkg::IDX_W-1:0] i,
                                               input logic [fcm_pkg::IDX_W-1:0] j);
      int            n;
      int            ne;
      longint        acc_re;
      longint        acc_im;
      longint        ar, ai, br, bi;
      corr_pair_type c;
      n = size_reg;
      if (n == 0)
         n = 1;
      if (n > SITES)
         n = SITES;
      ne = (fill_reg < n) ? int'(fill_reg) : n;
      c = '0;
      if (i >= n || j >= n)
         return c;
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < ne; k++) begin
         ar = orb_re[i][k];
         ai = orb_im[i][k];
         br = orb_re[j][k];
         bi = orb_im[j][k];
         acc_re += ar * br + ai * bi;
         acc_im += ar * bi - ai * br;
      end
      c.re = to_q5_26(acc_re);
      c.im = to_q5_26(acc_im);
      return c;
   endfunction

   // watch all three channels at each edge
   always @(posedge clock) begin : monitor
      corr_pair_type want;
      if (reset) begin
         size_reg = fcm_pkg::CFG_W'(16);
         fill_reg = '0;
         corr_expected_q.delete();
      end else begin
         // register writes should land only while the block is idle; the block itself does not enforce this
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == fcm_pkg::CSR_SIZE_IN_USE)
               size_reg = csr_chan.data;
            else if (csr_chan.index == fcm_pkg::CSR_FILLED_COUNT)
               fill_reg = csr_chan.data;
         end

         // result item against the oldest expectation
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (corr_expected_q.size() == 0) begin
               $display("%0t: unexpected result item, expected none, got re %0d im %0d",
                        $time, rsp_chan.corr_re, rsp_chan.corr_im);
               errors++;
            end else begin
               want = corr_expected_q.pop_front();
               if (rsp_chan.corr_re !== want.re) begin
                  $display("%0t: corr_re mismatch, expected %0d, got %0d",
                           $time, want.re, rsp_chan.corr_re);
                  errors++;
               end
               if (rsp_chan.corr_im !== want.im) begin
                  $display("%0t: corr_im mismatch, expected %0d, got %0d",
                           $time, want.im, rsp_chan.corr_im);
                  errors++;
               end
            end
         end

         // request item: update the matrix or queue a prediction
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.mode == fcm_pkg::MODE_WRITE) begin
               orb_re[req_chan.row_index][req_chan.col_index] = req_chan.elem_re;
               orb_im[req_chan.row_index][req_chan.col_index] = req_chan.elem_im;
            end else begin
               corr_expected_q.push_back(correlate(req_chan.row_index,
                                                   req_chan.col_index));
            end
         end
      end
      results_due = corr_expected_q.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the correlation matrix block. A short directed
// pass covers the value extremes, zero and saturated sums; then random
// phases move through register settings, fill the rows that reads need and
// mix in stray writes and reads outside the active size. Both channels
// idle and stall at random; a monitor beside the block does the checking.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SITES          = 16;
   localparam int DRAIN_CYCLES   = 2 * (SITES + 5) + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1000;
   localparam int PHASE_ITEMS    = 100;
   localparam int NUM_SET_PHASES = 9;

   localparam logic signed [fcm_pkg::ELEM_W-1:0] ELEM_MIN = 16'sh8000;
   localparam logic signed [fcm_pkg::ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;

   // fixed register settings walked first, extremes among them
   localparam int PHASE_SIZE [NUM_SET_PHASES] = '{0, 1, 31, 4, 8, 3, 16, 5, 2};
   localparam int PHASE_FILL [NUM_SET_PHASES] = '{5, 0, 31, 2, 20, 3, 16, 1, 31};

   logic clock = 1'b0;
   logic reset;

   fcm_req_if req_chan ();
   fcm_rsp_if rsp_chan ();
   fcm_csr_if csr_chan ();

   int errors;
   int results_due;

   bit send_gaps_on  = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int stall_left    = 0;
   int idle_cycles   = 0;
   int item_count    = 0;

   // which columns of each row hold a written element
   logic [SITES-1:0]           written_cols [SITES];
   logic [fcm_pkg::CFG_W-1:0]  size_now;
   logic [fcm_pkg::FILL_W-1:0] fill_now;

   fermion_correlation_matrix #(
      .MAX_SITES (SITES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   fcm_corr_check #(
      .SITES (SITES)
   ) corr_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_chan    (csr_chan),
      .errors      (errors),
      .results_due (results_due)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // result side back-pressure: mostly short stalls, a few long ones
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (rsp_stalls_on && $urandom_range(0, 99) < 25) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 60);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!send_gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [fcm_pkg::ELEM_W-1:0] pick_elem();
      case ($urandom_range(0, 9))
         0:       return ELEM_MIN;
         1:       return ELEM_MAX;
         2:       return '0;
         3:       return '1;
         default: return fcm_pkg::ELEM_W'($urandom);
      endcase
   endfunction

   function automatic int active_sites();
      int n;
      n = size_now;
      if (n == 0)
         n = 1;
      if (n > SITES)
         n = SITES;
      return n;
   endfunction

   function automatic int summed_cols();
      int n;
      n = active_sites();
      return (fill_now < n) ? int'(fill_now) : n;
   endfunction

   // mostly inside the active size, sometimes anywhere
   function automatic logic [fcm_pkg::IDX_W-1:0] pick_index(input int n);
      if ($urandom_range(0, 9) < 8)
         return fcm_pkg::IDX_W'($urandom_range(0, n - 1));
      return fcm_pkg::IDX_W'($urandom_range(0, SITES - 1));
   endfunction

   // one request item, held until the block takes it
   task automatic send_req(input logic mode, input logic [fcm_pkg::IDX_W-1:0] row,
                           input logic [fcm_pkg::IDX_W-1:0] col,
                           input logic signed [fcm_pkg::ELEM_W-1:0] elem_re,
                           input logic signed [fcm_pkg::ELEM_W-1:0] elem_im);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.mode      <= mode;
      req_chan.row_index <= row;
      req_chan.col_index <= col;
      req_chan.elem_re   <= elem_re;
      req_chan.elem_im   <= elem_im;
      do @(posedge clock); while (!req_chan.ready);
      if (mode == fcm_pkg::MODE_WRITE)
         written_cols[row][col] = 1'b1;
      item_count++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (results_due == 0);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [fcm_pkg::CSR_IDX_W-1:0] index,
                            input logic [fcm_pkg::CFG_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // registers change only once the block has gone quiet
   task automatic set_config(input int size, input int fill);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(fcm_pkg::CSR_SIZE_IN_USE, fcm_pkg::CFG_W'(size));
      write_reg(fcm_pkg::CSR_FILLED_COUNT, fcm_pkg::CFG_W'(fill));
      csr_chan.valid <= 1'b0;
      size_now = fcm_pkg::CFG_W'(size);
      fill_now = fcm_pkg::FILL_W'(fill);
   endtask

   // write any missing summed columns of a row before it is read
   task automatic fill_row(input logic [fcm_pkg::IDX_W-1:0] row, input int ne);
      bit                                flat;
      logic signed [fcm_pkg::ELEM_W-1:0] flat_re;
      logic signed [fcm_pkg::ELEM_W-1:0] flat_im;
      flat    = ($urandom_range(0, 3) == 0);
      flat_re = $urandom_range(0, 1) ? ELEM_MIN : ELEM_MAX;
      flat_im = $urandom_range(0, 1) ? ELEM_MIN : ELEM_MAX;
      for (int k = 0; k < ne; k++) begin
         if (!written_cols[row][k])
            send_req(fcm_pkg::MODE_WRITE, row, fcm_pkg::IDX_W'(k),
                     flat ? flat_re : pick_elem(), flat ? flat_im : pick_elem());
      end
   endtask

   task automatic random_item();
      int                        n;
      int                        ne;
      logic [fcm_pkg::IDX_W-1:0] i;
      logic [fcm_pkg::IDX_W-1:0] j;
      n  = active_sites();
      ne = summed_cols();
      if ($urandom_range(0, 99) < 35) begin
         i = pick_index(n);
         j = (ne > 0 && $urandom_range(0, 9) < 7) ?
             fcm_pkg::IDX_W'($urandom_range(0, ne - 1)) :
             fcm_pkg::IDX_W'($urandom_range(0, SITES - 1));
         send_req(fcm_pkg::MODE_WRITE, i, j, pick_elem(), pick_elem());
      end else begin
         i = pick_index(n);
         j = pick_index(n);
         if (i < n && j < n) begin
            fill_row(i, ne);
            fill_row(j, ne);
         end
         send_req(fcm_pkg::MODE_READ, i, j, fcm_pkg::ELEM_W'($urandom),
                  fcm_pkg::ELEM_W'($urandom));
      end
   endtask

   initial begin : stimulus
      int phase;
      int base;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.mode      <= fcm_pkg::MODE_WRITE;
      req_chan.row_index <= '0;
      req_chan.col_index <= '0;
      req_chan.elem_re   <= '0;
      req_chan.elem_im   <= '0;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= fcm_pkg::CSR_SIZE_IN_USE;
      csr_chan.data      <= '0;
      for (int r = 0; r < SITES; r++)
         written_cols[r] = '0;
      size_now = fcm_pkg::CFG_W'(16);
      fill_now = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: nothing summed, result is zero
      send_req(fcm_pkg::MODE_READ, 4'd15, 4'd15, ELEM_MAX, ELEM_MIN);

      // corner elements, then two-column sums over them
      send_req(fcm_pkg::MODE_WRITE, 4'd0, 4'd0, ELEM_MIN, ELEM_MIN);
      send_req(fcm_pkg::MODE_WRITE, 4'd0, 4'd1, ELEM_MAX, ELEM_MAX);
      send_req(fcm_pkg::MODE_WRITE, 4'd1, 4'd0, ELEM_MIN, ELEM_MAX);
      send_req(fcm_pkg::MODE_WRITE, 4'd1, 4'd1, ELEM_MAX, ELEM_MIN);
      send_req(fcm_pkg::MODE_WRITE, 4'd15, 4'd15, ELEM_MAX, ELEM_MIN);
      set_config(16, 2);
      send_req(fcm_pkg::MODE_READ, 4'd0, 4'd0, '0, '0);
      send_req(fcm_pkg::MODE_READ, 4'd0, 4'd1, '0, '0);
      send_req(fcm_pkg::MODE_READ, 4'd1, 4'd0, '0, '0);
      send_req(fcm_pkg::MODE_READ, 4'd1, 4'd1, '0, '0);

      // full row of most negative values: the sum saturates
      set_config(31, 31);
      for (int k = 0; k < SITES; k++)
         send_req(fcm_pkg::MODE_WRITE, 4'd2, fcm_pkg::IDX_W'(k), ELEM_MIN, ELEM_MIN);
      send_req(fcm_pkg::MODE_READ, 4'd2, 4'd2, '0, '0);

      // random phases over fixed, then random, register settings
      base  = item_count;
      phase = 0;
      while (item_count - base < RANDOM_ITEMS) begin
         if (phase < NUM_SET_PHASES)
            set_config(PHASE_SIZE[phase], PHASE_FILL[phase]);
         else
            set_config($urandom_range(0, 31), $urandom_range(0, 31));
         send_gaps_on  = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2)
               drain_results();
            random_item();
         end
         phase++;
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && results_due == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
